// ----- design/bpc_pkg.sv -----
// shared constants, divider step function and arithmetic shift helper for the pressure compensation block
package bpc_pkg;

   localparam int unsigned CalWidth  = 32;
   localparam int unsigned CalCount  = 5;
   localparam int unsigned CsrIdxW   = 3;
   localparam int unsigned DivBits   = 32;

   localparam logic [CsrIdxW-1:0] CsrAc1Ac2 = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrAc3Ac4 = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrAc5Ac6 = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrB1B2   = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrMcMd   = 3'd4;

   localparam logic [31:0] B6Offset  = 32'd4000;
   localparam logic [31:0] B7Scale   = 32'd50000;
   localparam logic [31:0] SignBit   = 32'h8000_0000;
   localparam logic [31:0] PCoefSq   = 32'd3038;
   localparam logic [31:0] PCoefLin  = 32'hFFFF_E343; // -7357
   localparam logic [31:0] PCoefOff  = 32'd3791;
   localparam logic [31:0] B4Offset  = 32'd32768;

   // one restoring step of an unsigned 32-bit divide
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] quo;
   } div_state_type;

   function automatic div_state_type div_step(div_state_type s, logic [31:0] d);
      logic [32:0] trial;
      div_state_type r;
      trial = {s.rem, s.quo[31]} - {1'b0, d};
      r.quo = {s.quo[30:0], ~trial[32]};
      r.rem = trial[32] ? {s.rem[30:0], s.quo[31]} : trial[31:0];
      return r;
   endfunction

   // asr on 32-bit wrapping values
   function automatic logic [31:0] asr(logic [31:0] v, int unsigned n);
      return 32'($signed(v) >>> n);
   endfunction

endpackage

// ----- design/bpc_div.sv -----
// pipelined unsigned 32-bit divider, one quotient bit per stage, with sideband
module bpc_div #(
   parameter int unsigned SideW = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [31:0]      in_num,
   input  logic [31:0]      in_den,
   input  logic [SideW-1:0] in_side,
   output logic             out_valid,
   output logic [31:0]      out_quo,
   output logic [SideW-1:0] out_side
);
   localparam int unsigned Steps = bpc_pkg::DivBits;

   bpc_pkg::div_state_type st_ff   [Steps];
   logic [31:0]            den_ff  [Steps];
   logic [SideW-1:0]       side_ff [Steps];
   logic [Steps-1:0]       vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Steps-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0]   <= bpc_pkg::div_step('{rem: 32'd0, quo: in_num}, in_den);
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int i = 1; i < Steps; i++) begin
            st_ff[i]   <= bpc_pkg::div_step(st_ff[i-1], den_ff[i-1]);
            den_ff[i]  <= den_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign out_quo   = st_ff[Steps-1].quo;
   assign out_side  = side_ff[Steps-1];
endmodule

// ----- design/bpc_temp.sv -----
// temperature path: x1, signed divide for x2, b5 and t
module bpc_temp (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [15:0] raw_temperature,
   input  logic [15:0] raw_pressure,
   input  logic [31:0] ac5,
   input  logic [31:0] ac6,
   input  logic [31:0] mc,
   input  logic [31:0] md,
   output logic        out_valid,
   output logic [31:0] out_b5,
   output logic [31:0] out_t,
   output logic [15:0] out_up,
   output logic        out_err
);
   // stage 1: product
   logic        v1_ff;
   logic [31:0] prod1_ff;
   logic [15:0] up1_ff;
   // stage 2: x1 and divisor
   logic        v2_ff;
   logic [31:0] x1_2_ff, den2_ff;
   logic [15:0] up2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod1_ff <= 32'(({16'd0, raw_temperature} - ac6) * ac5);
         up1_ff   <= raw_pressure;
         x1_2_ff  <= bpc_pkg::asr(prod1_ff, 15);
         den2_ff  <= bpc_pkg::asr(prod1_ff, 15) + md;
         up2_ff   <= up1_ff;
      end
   end

   logic [31:0] num, mag_n, mag_d;
   logic        neg;
   assign num   = {mc[20:0], 11'd0};
   assign neg   = num[31] ^ den2_ff[31];
   assign mag_n = num[31] ? 32'd0 - num : num;
   assign mag_d = den2_ff[31] ? 32'd0 - den2_ff : den2_ff;

   localparam int unsigned SideW = 32 + 16 + 2;
   logic             dv;
   logic [31:0]      dq;
   logic [SideW-1:0] ds;

   bpc_div #(.SideW(SideW)) u_div (
      .clock, .reset, .advance,
      .in_valid (v2_ff),
      .in_num   (mag_n),
      .in_den   (mag_d),
      .in_side  ({x1_2_ff, up2_ff, neg, den2_ff == 32'd0}),
      .out_valid(dv),
      .out_quo  (dq),
      .out_side (ds)
   );

   logic [31:0] x2, b5;
   assign x2 = ds[1] ? 32'd0 - dq : dq;
   assign b5 = ds[SideW-1 -: 32] + x2;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (advance) begin
         out_valid <= dv;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_b5  <= b5;
         out_t   <= bpc_pkg::asr(b5 + 32'd8, 4);
         out_up  <= ds[17:2];
         out_err <= ds[0];
      end
   end
endmodule

// ----- design/bpc_pres.sv -----
// pressure path: b3, b4, b7, unsigned divide, final correction and saturation
module bpc_pres (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [31:0] in_b5,
   input  logic [31:0] in_t,
   input  logic [15:0] in_up,
   input  logic        in_err,
   input  logic [31:0] ac1,
   input  logic [31:0] ac2,
   input  logic [31:0] ac3,
   input  logic [31:0] ac4,
   input  logic [31:0] b1,
   input  logic [31:0] b2,
   output logic        out_valid,
   output logic [15:0] out_temperature,
   output logic [17:0] out_pressure,
   output logic        out_err
);
   localparam int unsigned Stages = 5;
   logic [Stages-1:0] v_ff;
   logic [31:0] t_ff   [Stages];
   logic [15:0] up_ff  [Stages];
   logic        err_ff [Stages];

   function automatic logic [31:0] sdiv4(logic [31:0] a);
      logic [31:0] m;
      m = a[31] ? 32'd0 - a : a;
      m = {2'b00, m[31:2]};
      return a[31] ? 32'd0 - m : m;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[Stages-2:0], in_valid};
      end
   end

   // s0: b6 and b6^2
   logic [31:0] b6_0, sq_0;
   // s1: bsq and the ac2, ac3 products
   logic [31:0] bsq_1, p_ac2_1, p_ac3_1;
   // s2: b2, b1 products
   logic [31:0] p_b2_2, p_b1_2, x2a_2, x1b_2;
   // s3: b3, x3
   logic [31:0] b3_3, x3_3;
   // s4: b4 product, up - b3
   logic [31:0] b4p_4, d_4;

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff[0]   <= in_t;
         up_ff[0]  <= in_up;
         err_ff[0] <= in_err;
         for (int i = 1; i < Stages; i++) begin
            t_ff[i]   <= t_ff[i-1];
            up_ff[i]  <= up_ff[i-1];
            err_ff[i] <= err_ff[i-1];
         end
         b6_0    <= in_b5 - bpc_pkg::B6Offset;
         sq_0    <= 32'((in_b5 - bpc_pkg::B6Offset) * (in_b5 - bpc_pkg::B6Offset));
         bsq_1   <= bpc_pkg::asr(sq_0, 12);
         p_ac2_1 <= 32'(ac2 * b6_0);
         p_ac3_1 <= 32'(ac3 * b6_0);
         p_b2_2  <= 32'(b2 * bsq_1);
         p_b1_2  <= 32'(b1 * bsq_1);
         x2a_2   <= bpc_pkg::asr(p_ac2_1, 11);
         x1b_2   <= bpc_pkg::asr(p_ac3_1, 13);
         b3_3    <= sdiv4({ac1[29:0], 2'b00} + bpc_pkg::asr(p_b2_2, 11) + x2a_2 + 32'd2);
         x3_3    <= bpc_pkg::asr(x1b_2 + bpc_pkg::asr(p_b1_2, 16) + 32'd2, 2);
         b4p_4   <= 32'(ac4 * (x3_3 + bpc_pkg::B4Offset));
         d_4     <= {16'd0, up_ff[3]} - b3_3;
      end
   end

   // s5: b4 and b7
   logic        v5_ff, err5_ff;
   logic [31:0] b4_5_ff, b7_5_ff, t5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v_ff[Stages-1];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         b4_5_ff <= {15'd0, b4p_4[31:15]};
         b7_5_ff <= 32'(d_4 * bpc_pkg::B7Scale);
         t5_ff   <= t_ff[Stages-1];
         err5_ff <= err_ff[Stages-1];
      end
   end

   logic        big;
   logic        zero_b4;
   assign big     = b7_5_ff >= bpc_pkg::SignBit;
   assign zero_b4 = b4_5_ff == 32'd0;

   localparam int unsigned SideW = 32 + 2;
   logic             dv;
   logic [31:0]      dq;
   logic [SideW-1:0] ds;

   bpc_div #(.SideW(SideW)) u_div (
      .clock, .reset, .advance,
      .in_valid (v5_ff),
      .in_num   (big ? b7_5_ff : {b7_5_ff[30:0], 1'b0}),
      .in_den   (b4_5_ff),
      .in_side  ({t5_ff, big, err5_ff | zero_b4}),
      .out_valid(dv),
      .out_quo  (dq),
      .out_side (ds)
   );

   // c0: p, shifted square
   logic        c0v_ff, c1v_ff, c2v_ff;
   logic [31:0] p0_ff, sq0_ff, lin0_ff, t0_ff;
   logic        e0_ff;
   logic [31:0] p1_ff, m1_ff, lin1_ff, t1_ff;
   logic        e1_ff;
   logic [31:0] p8, pq;
   assign pq = ds[1] ? {dq[30:0], 1'b0} : dq;
   assign p8 = bpc_pkg::asr(pq, 8);

   always_ff @(posedge clock) begin
      if (reset) begin
         c0v_ff <= 1'b0;
         c1v_ff <= 1'b0;
         c2v_ff <= 1'b0;
      end else if (advance) begin
         c0v_ff <= dv;
         c1v_ff <= c0v_ff;
         c2v_ff <= c1v_ff;
      end
   end

   logic [31:0] pf, x1f, tt;
   always_comb begin
      x1f = bpc_pkg::asr(m1_ff, 16);
      pf  = p1_ff + bpc_pkg::asr(x1f + lin1_ff + bpc_pkg::PCoefOff, 4);
   end
   assign tt = t1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff   <= pq;
         sq0_ff  <= 32'(p8 * p8);
         lin0_ff <= 32'(bpc_pkg::PCoefLin * pq);
         t0_ff   <= ds[SideW-1 -: 32];
         e0_ff   <= ds[0];
         p1_ff   <= p0_ff;
         m1_ff   <= 32'(sq0_ff * bpc_pkg::PCoefSq);
         lin1_ff <= bpc_pkg::asr(lin0_ff, 16);
         t1_ff   <= t0_ff;
         e1_ff   <= e0_ff;
         out_err <= e1_ff;
         if (e1_ff) begin
            out_temperature <= '0;
         end else if (tt[31]) begin
            out_temperature <= (tt >= 32'hFFFF_8000) ? tt[15:0] : 16'h8000;
         end else begin
            out_temperature <= (tt > 32'd32767) ? 16'h7FFF : tt[15:0];
         end
         if (e1_ff || pf[31]) begin
            out_pressure <= '0;
         end else begin
            out_pressure <= (pf > 32'd262143) ? 18'h3FFFF : pf[17:0];
         end
      end
   end
   assign out_valid = c2v_ff;
endmodule

// ----- design/barometric_pressure_compensation.sv -----
// top level of the barometric pressure and temperature compensation pipeline
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  raw_temperature, raw_pressure
//   rsp      out        rsp_valid / rsp_stall  temperature, pressure, divide_error
//   csr      in         csr_write_enable       csr_index, csr_write_data
//
// one beat per cycle in and out while no stalled output beat holds the pipe; each beat
// passes through the two 32-stage bit-per-stage dividers (temperature x2 and final
// pressure) in series plus 12 arithmetic stages around them
// the whole pipe advances together; a stalled output beat freezes every stage
// and holds every beat in flight for as long as the stall lasts
// reset clears valid bits and the calibration registers
module barometric_pressure_compensation #(
   parameter int unsigned CalW = bpc_pkg::CalWidth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [15:0]                 req_raw_temperature,
   input  logic [15:0]                 req_raw_pressure,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_temperature,
   output logic [17:0]                 rsp_pressure,
   output logic                        rsp_divide_error,
   input  logic                        csr_write_enable,
   input  logic [bpc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [CalW-1:0]             csr_write_data
);
   logic [CalW-1:0] cal_ff [bpc_pkg::CalCount];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bpc_pkg::CalCount; i++) cal_ff[i] <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bpc_pkg::CsrAc1Ac2: cal_ff[0] <= csr_write_data;
            bpc_pkg::CsrAc3Ac4: cal_ff[1] <= csr_write_data;
            bpc_pkg::CsrAc5Ac6: cal_ff[2] <= csr_write_data;
            bpc_pkg::CsrB1B2:   cal_ff[3] <= csr_write_data;
            bpc_pkg::CsrMcMd:   cal_ff[4] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // calibration words widened to 32 bits
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{cal_ff[0][31]}}, cal_ff[0][31:16]};
   assign ac2 = {{16{cal_ff[0][15]}}, cal_ff[0][15:0]};
   assign ac3 = {{16{cal_ff[1][31]}}, cal_ff[1][31:16]};
   assign ac4 = {16'd0, cal_ff[1][15:0]};
   assign ac5 = {16'd0, cal_ff[2][31:16]};
   assign ac6 = {16'd0, cal_ff[2][15:0]};
   assign b1  = {{16{cal_ff[3][31]}}, cal_ff[3][31:16]};
   assign b2  = {{16{cal_ff[3][15]}}, cal_ff[3][15:0]};
   assign mc  = {{16{cal_ff[4][31]}}, cal_ff[4][31:16]};
   assign md  = {{16{cal_ff[4][15]}}, cal_ff[4][15:0]};

   // pipe moves whenever the output slot is empty or being taken
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   logic        tv, terr;
   logic [31:0] tb5, tt;
   logic [15:0] tup;
   logic [15:0] temp_out;

   bpc_temp u_temp (
      .clock, .reset, .advance,
      .in_valid       (req_valid),
      .raw_temperature(req_raw_temperature),
      .raw_pressure   (req_raw_pressure),
      .ac5, .ac6, .mc, .md,
      .out_valid(tv), .out_b5(tb5), .out_t(tt), .out_up(tup), .out_err(terr)
   );

   bpc_pres u_pres (
      .clock, .reset, .advance,
      .in_valid(tv), .in_b5(tb5), .in_t(tt), .in_up(tup), .in_err(terr),
      .ac1, .ac2, .ac3, .ac4, .b1, .b2,
      .out_valid      (rsp_valid),
      .out_temperature(temp_out),
      .out_pressure   (rsp_pressure),
      .out_err        (rsp_divide_error)
   );

   assign rsp_temperature = $signed(temp_out);
endmodule

// ----- tb/sv/tb_barometric_pressure_compensation.sv -----
// self-checking testbench for the barometric pressure compensation pipeline
module tb_barometric_pressure_compensation;

   localparam int unsigned IdleLimit  = 4000;  // cycles with no beat on either channel
   localparam int unsigned DrainWait  = 120;   // a bit over the pipe latency
   localparam int unsigned LongHold   = 500;   // long receiver hold-off in cycles
   localparam logic [bpc_pkg::CsrIdxW-1:0] CsrUnused = 3'd7;

   typedef struct {
      logic signed [15:0] temperature;
      logic [17:0]        pressure;
      logic               divide_error;
   } reading_type;

   // keeps its own calibration copy and the queue of readings still owed by the pipe
   class compensation_scoreboard;
      logic [31:0] cal [bpc_pkg::CalCount];
      reading_type owed [$];
      int unsigned errors;

      function new();
         foreach (cal[i]) cal[i] = '0;
         errors = 0;
      endfunction

      function void write_cal(logic [bpc_pkg::CsrIdxW-1:0] idx, logic [31:0] val);
         if (idx < bpc_pkg::CalCount) cal[idx] = val;
      endfunction

      static function logic [31:0] ext16(logic [15:0] v);
         return {{16{v[15]}}, v};
      endfunction

      static function logic [31:0] shr_s(logic [31:0] v, int unsigned n);
         return 32'($signed(v) >>> n);
      endfunction

      // truncating signed division on 32-bit patterns, wraps on overflow
      static function logic [31:0] div_s(logic [31:0] a, logic [31:0] b);
         logic [31:0] ma, mb, q;
         ma = a[31] ? -a : a;
         mb = b[31] ? -b : b;
         q  = ma / mb;
         return (a[31] != b[31]) ? -q : q;
      endfunction

      function reading_type compensate(logic [15:0] raw_t, logic [15:0] raw_p);
         logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
         logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, bsq, t, p, dv;
         reading_type r;
         ac1 = ext16(cal[0][31:16]);  ac2 = ext16(cal[0][15:0]);
         ac3 = ext16(cal[1][31:16]);  ac4 = {16'd0, cal[1][15:0]};
         ac5 = {16'd0, cal[2][31:16]}; ac6 = {16'd0, cal[2][15:0]};
         b1  = ext16(cal[3][31:16]);  b2  = ext16(cal[3][15:0]);
         mc  = ext16(cal[4][31:16]);  md  = ext16(cal[4][15:0]);
         ut  = {16'd0, raw_t};        up  = {16'd0, raw_p};
         r.temperature = '0; r.pressure = '0; r.divide_error = 1'b1;
         // temperature path
         x1 = shr_s((ut - ac6) * ac5, 15);
         dv = x1 + md;
         if (dv == 0) return r;
         x2 = div_s(mc * 32'd2048, dv);
         b5 = x1 + x2;
         t  = shr_s(b5 + 32'd8, 4);
         // pressure path
         b6  = b5 - bpc_pkg::B6Offset;
         bsq = shr_s(b6 * b6, 12);
         x1  = shr_s(b2 * bsq, 11);
         x2  = shr_s(ac2 * b6, 11);
         x3  = x1 + x2;
         b3  = div_s(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
         x1  = shr_s(ac3 * b6, 13);
         x2  = shr_s(b1 * bsq, 16);
         x3  = shr_s(x1 + x2 + 32'd2, 2);
         b4  = (ac4 * (x3 + bpc_pkg::B4Offset)) >> 15;
         if (b4 == 0) return r;
         b7 = (up - b3) * bpc_pkg::B7Scale;
         if (b7 < bpc_pkg::SignBit) p = (b7 * 32'd2) / b4;
         else p = (b7 / b4) * 32'd2;
         x1 = shr_s(p, 8) * shr_s(p, 8);
         x1 = shr_s(x1 * bpc_pkg::PCoefSq, 16);
         x2 = shr_s(bpc_pkg::PCoefLin * p, 16);
         p  = p + shr_s(x1 + x2 + bpc_pkg::PCoefOff, 4);
         // clamp both outputs
         if (t[31]) r.temperature = (t >= 32'hFFFF_8000) ? t[15:0] : 16'h8000;
         else r.temperature = (t > 32'd32767) ? 16'h7FFF : t[15:0];
         if (p[31]) r.pressure = '0;
         else r.pressure = (p > 32'd262143) ? 18'h3FFFF : p[17:0];
         r.divide_error = 1'b0;
         return r;
      endfunction

      function void note_sample(logic [15:0] raw_t, logic [15:0] raw_p);
         owed.push_back(compensate(raw_t, raw_p));
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_reading(reading_type got);
         reading_type want;
         if (owed.size() == 0) begin
            report($sformatf("unexpected beat t=%0d p=%0d err=%0b",
               got.temperature, got.pressure, got.divide_error));
            return;
         end
         want = owed.pop_front();
         if (got.temperature !== want.temperature)
            report($sformatf("temperature %0d, want %0d",
               got.temperature, want.temperature));
         if (got.pressure !== want.pressure)
            report($sformatf("pressure %0d, want %0d", got.pressure, want.pressure));
         if (got.divide_error !== want.divide_error)
            report($sformatf("divide_error %0b, want %0b",
               got.divide_error, want.divide_error));
      endtask
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [15:0]                 req_raw_temperature = '0;
   logic [15:0]                 req_raw_pressure = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [15:0]          rsp_temperature;
   logic [17:0]                 rsp_pressure;
   logic                        rsp_divide_error;
   logic                        csr_write_enable = 1'b0;
   logic [bpc_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [31:0]                 csr_write_data = '0;

   compensation_scoreboard readings = new();
   int unsigned burst_left = 0;
   bit          hold_request = 1'b0;
   int unsigned idle_cycles = 0;

   barometric_pressure_compensation dut (.*);

   always #6 clock = ~clock;

   // input monitor: predict every accepted beat with the calibration in force now
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         readings.note_sample(req_raw_temperature, req_raw_pressure);
   end

   // output monitor
   always @(posedge clock) begin
      reading_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.temperature  = rsp_temperature;
         got.pressure     = rsp_pressure;
         got.divide_error = rsp_divide_error;
         readings.check_reading(got);
      end
   end

   // receiver: stall rate redrawn for each phase, plus one long hold-off on request
   always @(posedge clock) begin
      int unsigned hold_left;
      int unsigned phase_cnt;
      int unsigned stall_pct;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LongHold;
         rsp_stall <= 1'b1;
      end else begin
         if (phase_cnt == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
            phase_cnt = 64;
         end
         phase_cnt--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // watchdog: ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
         $display("tb_barometric_pressure_compensation NOT OK");
         $finish;
      end
   end

   task automatic write_cal(logic [bpc_pkg::CsrIdxW-1:0] idx, logic [31:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      readings.write_cal(idx, val);
   endtask

   task automatic write_all_cal(logic [31:0] v0, v1, v2, v3, v4);
      write_cal(bpc_pkg::CsrAc1Ac2, v0);
      write_cal(bpc_pkg::CsrAc3Ac4, v1);
      write_cal(bpc_pkg::CsrAc5Ac6, v2);
      write_cal(bpc_pkg::CsrB1B2, v3);
      write_cal(bpc_pkg::CsrMcMd, v4);
   endtask

   // sends one beat; when bursty, bursts of random length separated by random gaps
   task automatic send_sample(logic [15:0] raw_t, logic [15:0] raw_p, bit bursty);
      if (bursty && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 10);
      end
      if (burst_left > 0) burst_left--;
      req_valid           <= 1'b1;
      req_raw_temperature <= raw_t;
      req_raw_pressure    <= raw_p;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering, then wait for every owed reading and let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (readings.owed.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   // calibration near a typical part, or fully random words
   task automatic random_cal();
      if ($urandom_range(0, 2) != 0)
         write_all_cal({16'd408 + 16'($urandom_range(0, 400)),
                        16'hFFB8 + 16'($urandom_range(0, 60))},
                       {16'hC7D1 + 16'($urandom_range(0, 800)),
                        16'd32741 - 16'($urandom_range(0, 900))},
                       {16'd32757 - 16'($urandom_range(0, 9000)),
                        16'd23153 + 16'($urandom_range(0, 3000))},
                       {16'd6190 + 16'($urandom_range(0, 500)),
                        16'd4 + 16'($urandom_range(0, 20))},
                       {16'hDDF9 + 16'($urandom_range(0, 600)),
                        16'd2868 + 16'($urandom_range(0, 400))});
      else
         write_all_cal($urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: ac5 and md are zero, so every beat hits the temperature divisor error
      send_sample(16'd0, 16'd0, 1'b0);
      send_sample(16'hFFFF, 16'hFFFF, 1'b0);
      drain();

      // typical calibration, including the raw temperature top bit left unsigned
      write_all_cal({16'd408, 16'hFFB8}, {16'hC7D1, 16'd32741}, {16'd32757, 16'd23153},
                    {16'd6190, 16'd4}, {16'hDDF9, 16'd2868});
      write_cal(CsrUnused, 32'hFFFF_FFFF);  // ignored index
      send_sample(16'd27898, 16'd23843, 1'b0);
      send_sample(16'd0, 16'd0, 1'b0);
      send_sample(16'hFFFF, 16'hFFFF, 1'b0);
      send_sample(16'h8000, 16'h7FFF, 1'b0);
      send_sample(16'h7FFF, 16'h8000, 1'b0);
      send_sample(16'd23153, 16'd40000, 1'b0);
      drain();

      // ac4 zero makes the pressure divisor zero
      write_cal(bpc_pkg::CsrAc3Ac4, {16'hC7D1, 16'd0});
      send_sample(16'd27898, 16'd23843, 1'b0);
      send_sample(16'hFFFF, 16'd0, 1'b0);
      drain();

      // all-ones words: temperature divisor stays non-zero, with wide wrap in the products
      write_all_cal('1, '1, '1, '1, '1);
      send_sample(16'd0, 16'd0, 1'b0);
      send_sample(16'hFFFF, 16'hFFFF, 1'b0);
      send_sample(16'd1, 16'h8000, 1'b0);
      drain();

      // most negative and most positive words, driving both saturations
      write_all_cal(32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_0000, 32'h8000_8000,
                    32'h8000_7FFF);
      send_sample(16'd0, 16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 16'd0, 1'b0);
      drain();
      write_all_cal(32'h7FFF_7FFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_7FFF,
                    32'h7FFF_0001);
      send_sample(16'd0, 16'hFFFF, 1'b0);
      send_sample(16'hFFFF, 16'd0, 1'b0);
      send_sample(16'h5555, 16'hAAAA, 1'b0);
      drain();

      // random phases of 200 beats, each under its own calibration
      for (int unsigned ph = 0; ph < 8; ph++) begin
         random_cal();
         for (int unsigned n = 0; n < 200; n++) begin
            if (ph == 2 && n == 20) hold_request = 1'b1;  // long hold while we keep offering
            if (ph == 5 && n == 100) begin
               // pause until the pipe is empty, then continue
               req_valid <= 1'b0;
               burst_left = 0;
               @(posedge clock);
               while (readings.owed.size() != 0) @(posedge clock);
            end
            send_sample(16'($urandom), 16'($urandom), 1'b1);
         end
         drain();
      end

      if (readings.errors == 0)
         $display("tb_barometric_pressure_compensation OK");
      else
         $display("tb_barometric_pressure_compensation NOT OK");
      $finish;
   end

endmodule

// ----- barometric_pressure_compensation.f -----
design/bpc_pkg.sv
design/bpc_div.sv
design/bpc_temp.sv
design/bpc_pres.sv
design/barometric_pressure_compensation.sv
tb/sv/tb_barometric_pressure_compensation.sv
